@@ src/oro_pkg.sv @@
// Package: widths, defaults and shared types for the oriented rectangle overlap test.
package oro_pkg;

  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned DirBits      = 16;
  localparam int unsigned SizeBits     = 15;
  localparam int unsigned DirFrac      = 14;
  localparam int unsigned ProdBits     = 2 * DirBits;
  localparam int unsigned TermBits     = 2 * DirBits;
  localparam int unsigned ExtBits      = TermBits + SizeBits;
  localparam int unsigned NumAxes      = 4;

  typedef logic [TermBits-1:0] term_t;
  typedef logic [ExtBits-1:0]  ext_t;

  // Projection magnitudes that scale the four sizes on one axis
  typedef struct packed {
    term_t p;  // times a_width
    term_t q;  // times a_height
    term_t u;  // times b_width
    term_t v;  // times b_height
  } axis_terms_t;

  typedef struct packed {
    logic [SizeBits-1:0] aw;
    logic [SizeBits-1:0] ah;
    logic [SizeBits-1:0] bw;
    logic [SizeBits-1:0] bh;
  } sizes_t;

endpackage

@@ src/oro_axis.sv @@
// Per-axis separation test: projections, extent sum and compare over three stages.
module oro_axis
  import oro_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [COORD_BITS:0] dx_i,
  input  logic signed [COORD_BITS:0] dy_i,
  input  logic signed [DirBits:0] ax_i,
  input  logic signed [DirBits:0] ay_i,
  input  axis_terms_t             terms_i,
  input  sizes_t                  sizes_i,
  output logic                    sep_o
);

  localparam int unsigned DXW  = COORD_BITS + 1;
  localparam int unsigned AXW  = DirBits + 1;
  localparam int unsigned DPW  = DXW + AXW;
  localparam int unsigned DSW  = DPW + 1;
  localparam int unsigned RW   = ExtBits + 2;
  localparam int unsigned RSW  = RW - (DirFrac + 1);
  localparam int unsigned CMPW = (DSW > RSW) ? DSW : RSW;

  // stage A: products
  logic signed [DPW-1:0] dpx_q, dpy_q;
  ext_t                  e0_q, e1_q, e2_q, e3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dpx_q <= DPW'(dx_i) * DPW'(ax_i);
      dpy_q <= DPW'(dy_i) * DPW'(ay_i);
      e0_q  <= ExtBits'(terms_i.p) * ExtBits'(sizes_i.aw);
      e1_q  <= ExtBits'(terms_i.q) * ExtBits'(sizes_i.ah);
      e2_q  <= ExtBits'(terms_i.u) * ExtBits'(sizes_i.bw);
      e3_q  <= ExtBits'(terms_i.v) * ExtBits'(sizes_i.bh);
    end
  end

  // stage B: centre distance magnitude, partial extent sums
  logic signed [DSW-1:0] dsum;
  logic [DSW-1:0]        dmag_d, dmag_q;
  logic [ExtBits:0]      r01_q, r23_q;

  assign dsum   = DSW'(dpx_q) + DSW'(dpy_q);
  assign dmag_d = dsum[DSW-1] ? DSW'(-dsum) : DSW'(dsum);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dmag_q <= dmag_d;
      r01_q  <= (ExtBits+1)'(e0_q) + (ExtBits+1)'(e1_q);
      r23_q  <= (ExtBits+1)'(e2_q) + (ExtBits+1)'(e3_q);
    end
  end

  // stage C: strict compare against the halved extent sum
  logic [RW-1:0]  rsum;
  logic [RSW-1:0] rsh;
  logic           sep_d, sep_q;

  assign rsum  = RW'(r01_q) + RW'(r23_q);
  assign rsh   = rsum[RW-1:DirFrac+1];
  assign sep_d = CMPW'(dmag_q) > CMPW'(rsh);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sep_q <= sep_d;
    end
  end

  assign sep_o = sep_q;

endmodule

@@ src/oriented_rect_overlap_test_core.sv @@
// Top level: streaming separating axis test for pairs of oriented rectangles.
//
// Usage:
//   One request carries two rectangles (centre, forward direction, width, height)
//   on the input channel; one result bit, overlap_o, leaves on the output channel
//   for every request, in order. overlap_o is 1 unless some edge axis separates
//   the pair; touching counts as overlap.
// Pipeline: five register stages; out_valid_o rises with the edge that loads the
//   last stage, so the result is presented together with its valid bit.
// Throughput: one request per cycle, set by the five-stage multiply/add pipeline
//   (direction products, dot/cross terms, projections, extent sums, compare).
// Stall: the whole pipeline advances only while the output register is empty
//   or being taken, so in_ready_o = !out_valid_o || out_ready_i. A stalled
//   receiver holds every stage in place; nothing is dropped or repeated.
// Reset: rst_ni clears all stage valid bits asynchronously; the pipeline comes
//   up empty and ready.
module oriented_rect_overlap_test_core
  import oro_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] a_center_x_i,
  input  logic signed [COORD_BITS-1:0] a_center_y_i,
  input  logic signed [DirBits-1:0]    a_dir_x_i,
  input  logic signed [DirBits-1:0]    a_dir_y_i,
  input  logic [SizeBits-1:0]          a_width_i,
  input  logic [SizeBits-1:0]          a_height_i,
  input  logic signed [COORD_BITS-1:0] b_center_x_i,
  input  logic signed [COORD_BITS-1:0] b_center_y_i,
  input  logic signed [DirBits-1:0]    b_dir_x_i,
  input  logic signed [DirBits-1:0]    b_dir_y_i,
  input  logic [SizeBits-1:0]          b_width_i,
  input  logic [SizeBits-1:0]          b_height_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         overlap_o
);

  localparam int unsigned DXW    = COORD_BITS + 1;
  localparam int unsigned AXW    = DirBits + 1;
  localparam int unsigned Stages = 5;

  logic              en;
  logic [Stages-1:0] v_q, v_d;

  assign en         = !v_q[Stages-1] || out_ready_i;
  assign in_ready_o = en;
  assign v_d        = {v_q[Stages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= v_d;
    end
  end

  // stage 1: centre offset and direction products
  logic signed [DXW-1:0]      dx1_q, dy1_q;
  logic signed [ProdBits-1:0] aa_xx_q, aa_yy_q, bb_xx_q, bb_yy_q;
  logic signed [ProdBits-1:0] ab_xx_q, ab_yy_q, ab_xy_q, ab_yx_q;
  logic signed [DirBits-1:0]  afx1_q, afy1_q, bfx1_q, bfy1_q;
  sizes_t                     sz1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx1_q   <= DXW'(a_center_x_i) - DXW'(b_center_x_i);
      dy1_q   <= DXW'(a_center_y_i) - DXW'(b_center_y_i);
      aa_xx_q <= ProdBits'(a_dir_x_i) * ProdBits'(a_dir_x_i);
      aa_yy_q <= ProdBits'(a_dir_y_i) * ProdBits'(a_dir_y_i);
      bb_xx_q <= ProdBits'(b_dir_x_i) * ProdBits'(b_dir_x_i);
      bb_yy_q <= ProdBits'(b_dir_y_i) * ProdBits'(b_dir_y_i);
      ab_xx_q <= ProdBits'(a_dir_x_i) * ProdBits'(b_dir_x_i);
      ab_yy_q <= ProdBits'(a_dir_y_i) * ProdBits'(b_dir_y_i);
      ab_xy_q <= ProdBits'(a_dir_x_i) * ProdBits'(b_dir_y_i);
      ab_yx_q <= ProdBits'(a_dir_y_i) * ProdBits'(b_dir_x_i);
      afx1_q  <= a_dir_x_i;
      afy1_q  <= a_dir_y_i;
      bfx1_q  <= b_dir_x_i;
      bfy1_q  <= b_dir_y_i;
      sz1_q   <= '{aw: a_width_i, ah: a_height_i, bw: b_width_i, bh: b_height_i};
    end
  end

  // stage 2: squared norms, |dot| and |cross| of the two directions
  logic signed [ProdBits:0] na_s, nb_s, c_s, s_s;
  term_t                    na, nb, cmag, smag;

  assign na_s = (ProdBits+1)'(aa_xx_q) + (ProdBits+1)'(aa_yy_q);
  assign nb_s = (ProdBits+1)'(bb_xx_q) + (ProdBits+1)'(bb_yy_q);
  assign c_s  = (ProdBits+1)'(ab_xx_q) + (ProdBits+1)'(ab_yy_q);
  assign s_s  = (ProdBits+1)'(ab_yx_q) - (ProdBits+1)'(ab_xy_q);
  assign na   = na_s[TermBits-1:0];
  assign nb   = nb_s[TermBits-1:0];
  assign cmag = c_s[ProdBits] ? TermBits'(-c_s) : c_s[TermBits-1:0];
  assign smag = s_s[ProdBits] ? TermBits'(-s_s) : s_s[TermBits-1:0];

  logic signed [DXW-1:0] dx2_q, dy2_q;
  logic signed [AXW-1:0] ax_q [NumAxes];
  logic signed [AXW-1:0] ay_q [NumAxes];
  axis_terms_t           terms_q [NumAxes];
  sizes_t                sz2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx2_q      <= dx1_q;
      dy2_q      <= dy1_q;
      sz2_q      <= sz1_q;
      // forward and up of each rectangle; up = (-fy, fx)
      ax_q[0]    <= AXW'(afx1_q);
      ay_q[0]    <= AXW'(afy1_q);
      ax_q[1]    <= -AXW'(afy1_q);
      ay_q[1]    <= AXW'(afx1_q);
      ax_q[2]    <= AXW'(bfx1_q);
      ay_q[2]    <= AXW'(bfy1_q);
      ax_q[3]    <= -AXW'(bfy1_q);
      ay_q[3]    <= AXW'(bfx1_q);
      terms_q[0] <= '{p: na,   q: '0,   u: cmag, v: smag};
      terms_q[1] <= '{p: '0,   q: na,   u: smag, v: cmag};
      terms_q[2] <= '{p: cmag, q: smag, u: nb,   v: '0};
      terms_q[3] <= '{p: smag, q: cmag, u: '0,   v: nb};
    end
  end

  // stages 3 to 5: one unit per axis
  logic [NumAxes-1:0] sep;

  for (genvar g = 0; g < NumAxes; g++) begin : g_axis
    oro_axis #(
      .COORD_BITS(COORD_BITS)
    ) u_axis (
      .clk_i  (clk_i),
      .en_i   (en),
      .dx_i   (dx2_q),
      .dy_i   (dy2_q),
      .ax_i   (ax_q[g]),
      .ay_i   (ay_q[g]),
      .terms_i(terms_q[g]),
      .sizes_i(sz2_q),
      .sep_o  (sep[g])
    );
  end

  assign out_valid_o = v_q[Stages-1];
  assign overlap_o   = ~|sep;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("pipeline valid bits moved during a stall");

  a_valid_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && v_q[Stages-2] |=> out_valid_o)
    else $error("request lost between last two stages");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && !in_valid_i |=> !v_q[0])
    else $error("request entered without input valid");

endmodule

@@ tb/oriented_rect_overlap_test_core_test.sv @@
// Self-checking testbench for the oriented rectangle overlap core: directed and random pairs.

typedef struct {
  logic signed [oro_pkg::CoordBitsDef-1:0] cx;
  logic signed [oro_pkg::CoordBitsDef-1:0] cy;
  logic signed [oro_pkg::DirBits-1:0]      fx;
  logic signed [oro_pkg::DirBits-1:0]      fy;
  logic [oro_pkg::SizeBits-1:0]            w;
  logic [oro_pkg::SizeBits-1:0]            h;
} rect_t;

class overlap_scoreboard;
  bit expected_q[$];
  int mismatches;
  int checked;
  int overlaps;

  // doubled half extent of one rectangle along an axis
  function longint span_on_axis(rect_t r, longint ax, longint ay);
    longint fx;
    longint fy;
    longint fa;
    longint ua;
    fx = r.fx;
    fy = r.fy;
    fa = fx * ax + fy * ay;
    ua = fx * ay - fy * ax;
    if (fa < 0) fa = -fa;
    if (ua < 0) ua = -ua;
    return fa * longint'(r.w) + ua * longint'(r.h);
  endfunction

  function bit predict_overlap(rect_t a, rect_t b);
    longint dx;
    longint dy;
    longint ax[4];
    longint ay[4];
    longint d;
    longint r;
    bit hit;
    hit = 1'b1;
    dx = longint'(a.cx) - longint'(b.cx);
    dy = longint'(a.cy) - longint'(b.cy);
    ax[0] = a.fx;              ay[0] = a.fy;
    ax[1] = -longint'(a.fy);   ay[1] = a.fx;
    ax[2] = b.fx;              ay[2] = b.fy;
    ax[3] = -longint'(b.fy);   ay[3] = b.fx;
    for (int i = 0; i < oro_pkg::NumAxes; i++) begin
      d = dx * ax[i] + dy * ay[i];
      if (d < 0) d = -d;
      r = span_on_axis(a, ax[i], ay[i]) + span_on_axis(b, ax[i], ay[i]);
      if (d > (r >>> (oro_pkg::DirFrac + 1))) hit = 1'b0;
    end
    return hit;
  endfunction

  function void note_request(rect_t a, rect_t b);
    expected_q.push_back(predict_overlap(a, b));
  endfunction

  function void check_result(bit got);
    bit want;
    if (expected_q.size() == 0) begin
      $error("overlap result %0b with no request outstanding", got);
      mismatches++;
      return;
    end
    want = expected_q.pop_front();
    checked++;
    if (got) overlaps++;
    if (want !== got) begin
      $error("field overlap: expected %0b, actual %0b", want, got);
      mismatches++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module oriented_rect_overlap_test_core_test;
  import oro_pkg::*;

  localparam int NumRandom    = 400;
  localparam int WatchLimit   = 4000;
  localparam int HoldCycles   = 80;
  localparam int HoldAtResult = 120;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic signed [CoordBitsDef-1:0] a_center_x_i;
  logic signed [CoordBitsDef-1:0] a_center_y_i;
  logic signed [DirBits-1:0]      a_dir_x_i;
  logic signed [DirBits-1:0]      a_dir_y_i;
  logic [SizeBits-1:0]            a_width_i;
  logic [SizeBits-1:0]            a_height_i;
  logic signed [CoordBitsDef-1:0] b_center_x_i;
  logic signed [CoordBitsDef-1:0] b_center_y_i;
  logic signed [DirBits-1:0]      b_dir_x_i;
  logic signed [DirBits-1:0]      b_dir_y_i;
  logic [SizeBits-1:0]            b_width_i;
  logic [SizeBits-1:0]            b_height_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic                           overlap_o;

  overlap_scoreboard sb = new();
  bit steady;
  int sent;
  int directed_count;
  int idle_cycles = 0;

  oriented_rect_overlap_test_core #(.COORD_BITS(CoordBitsDef)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .a_center_x_i (a_center_x_i),
    .a_center_y_i (a_center_y_i),
    .a_dir_x_i    (a_dir_x_i),
    .a_dir_y_i    (a_dir_y_i),
    .a_width_i    (a_width_i),
    .a_height_i   (a_height_i),
    .b_center_x_i (b_center_x_i),
    .b_center_y_i (b_center_y_i),
    .b_dir_x_i    (b_dir_x_i),
    .b_dir_y_i    (b_dir_y_i),
    .b_width_i    (b_width_i),
    .b_height_i   (b_height_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .overlap_o    (overlap_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic rect_t mk_rect(int cx, int cy, int fx, int fy, int w, int h);
    rect_t r;
    r.cx = CoordBitsDef'(cx);
    r.cy = CoordBitsDef'(cy);
    r.fx = DirBits'(fx);
    r.fy = DirBits'(fy);
    r.w  = SizeBits'(w);
    r.h  = SizeBits'(h);
    return r;
  endfunction

  task automatic send_pair(rect_t a, rect_t b);
    if (!steady) begin
      while ($urandom_range(99) < 9) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    a_center_x_i <= a.cx;
    a_center_y_i <= a.cy;
    a_dir_x_i    <= a.fx;
    a_dir_y_i    <= a.fy;
    a_width_i    <= a.w;
    a_height_i   <= a.h;
    b_center_x_i <= b.cx;
    b_center_y_i <= b.cy;
    b_dir_x_i    <= b.fx;
    b_dir_y_i    <= b.fy;
    b_width_i    <= b.w;
    b_height_i   <= b.h;
    in_valid_i   <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(a, b);
    sent++;
  endtask

  task automatic send_directed(rect_t a, rect_t b);
    send_pair(a, b);
    directed_count++;
  endtask

  function automatic void random_dir(output int fx, output int fy);
    real t;
    t  = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
    fx = $rtoi(16384.0 * $cos(t));
    fy = $rtoi(16384.0 * $sin(t));
  endfunction

  task automatic send_random();
    rect_t a;
    rect_t b;
    int kind;
    int fx;
    int fy;
    int reach;
    int dx;
    int dy;
    int sz;
    kind = $urandom_range(99);
    if (kind < 15) begin
      a = mk_rect($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      b = mk_rect($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (kind < 30) begin
      // axis-aligned pairs placed at, just inside or just outside contact
      fx = $urandom_range(1) ? 16384 : -16384;
      a = mk_rect($urandom, $urandom, fx, 0, 2 * $urandom_range(0, 600),
                  2 * $urandom_range(0, 600));
      if ($urandom_range(1)) b = mk_rect(0, 0, 0, fx, 0, 0);
      else b = mk_rect(0, 0, -fx, 0, 0, 0);
      b.w = SizeBits'(2 * $urandom_range(0, 600));
      b.h = SizeBits'(2 * $urandom_range(0, 600));
      dy = int'($urandom_range(0, 40)) - 20;
      if (b.fx != 0) dx = (int'(a.w) + int'(b.w)) / 2;
      else dx = (int'(a.w) + int'(b.h)) / 2;
      dx = dx + int'($urandom_range(0, 2)) - 1;
      if ($urandom_range(1)) dx = -dx;
      if ($urandom_range(1)) begin
        b.cx = CoordBitsDef'(int'(a.cx) + dx);
        b.cy = CoordBitsDef'(int'(a.cy) + dy);
      end else begin
        b.cx = CoordBitsDef'(int'(a.cx) + dy);
        b.cy = CoordBitsDef'(int'(a.cy) +
               (b.fx != 0 ? (dx < 0 ? -1 : 1) * ((int'(a.h) + int'(b.h)) / 2)
                          : (dx < 0 ? -1 : 1) * ((int'(a.h) + int'(b.w)) / 2)));
      end
    end else begin
      sz = ($urandom_range(99) < 5) ? 32767 : 2047;
      random_dir(fx, fy);
      a = mk_rect(int'($urandom_range(0, 40000)) - 20000,
                  int'($urandom_range(0, 40000)) - 20000, fx, fy,
                  $urandom_range(0, sz), $urandom_range(0, sz));
      random_dir(fx, fy);
      b = mk_rect(0, 0, fx, fy, $urandom_range(0, sz), $urandom_range(0, sz));
      if ($urandom_range(99) < 3) begin
        a.fx = '0;
        a.fy = '0;
      end
      if ($urandom_range(99) < 3) begin
        b.fx = '0;
        b.fy = '0;
      end
      reach = (int'(a.w) + int'(a.h) + int'(b.w) + int'(b.h)) / 2 + 8;
      dx = int'($urandom_range(0, 2 * reach)) - reach;
      dy = int'($urandom_range(0, 2 * reach)) - reach;
      b.cx = CoordBitsDef'(int'(a.cx) + dx);
      b.cy = CoordBitsDef'(int'(a.cy) + dy);
    end
    send_pair(a, b);
  endtask

  // result side: checking, random stalls and one long hold-off
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(overlap_o);
      if (!held && sb.checked >= HoldAtResult) begin
        held = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= 9);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("timeout: %0d cycles without a transfer, %0d results pending",
                 idle_cycles, sb.pending());
        $display("oriented_rect_overlap_test_core_test: done, errors");
        $finish;
      end
    end
  end

  initial begin
    steady = 1'b0;
    sent = 0;
    directed_count = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    a_center_x_i = '0;
    a_center_y_i = '0;
    a_dir_x_i = '0;
    a_dir_y_i = '0;
    a_width_i = '0;
    a_height_i = '0;
    b_center_x_i = '0;
    b_center_y_i = '0;
    b_dir_x_i = '0;
    b_dir_y_i = '0;
    b_width_i = '0;
    b_height_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_directed(mk_rect(0, 0, 16384, 0, 32, 32), mk_rect(0, 0, 16384, 0, 32, 32));
    send_directed(mk_rect(-32768, -32768, 16384, 0, 16, 16),
                  mk_rect(32767, 32767, 16384, 0, 16, 16));
    // touching edges, then one LSB apart
    send_directed(mk_rect(0, 0, 16384, 0, 32, 32), mk_rect(32, 0, 16384, 0, 32, 32));
    send_directed(mk_rect(0, 0, 16384, 0, 32, 32), mk_rect(33, 0, 16384, 0, 32, 32));
    send_directed(mk_rect(0, 0, 0, 16384, 32, 32), mk_rect(0, -32, 16384, 0, 32, 32));
    send_directed(mk_rect(0, 0, 0, 16384, 32, 32), mk_rect(0, -33, 16384, 0, 32, 32));
    send_directed(mk_rect(-32768, 32767, 16384, 0, 32767, 32767),
                  mk_rect(32767, -32768, -16384, 0, 32767, 32767));
    // degenerate direction collapses a rectangle onto its centre
    send_directed(mk_rect(0, 0, 0, 0, 32767, 32767), mk_rect(100, 0, 16384, 0, 32, 32));
    send_directed(mk_rect(8, 0, 0, 0, 16, 16), mk_rect(0, 0, 16384, 0, 32, 32));
    send_directed(mk_rect(-32768, 0, 0, 0, 0, 0), mk_rect(32767, 0, 0, 0, 0, 0));
    send_directed(mk_rect(0, 0, -32768, -32768, 64, 64), mk_rect(200, 0, 16384, 0, 16, 16));
    send_directed(mk_rect(0, 0, -32768, 0, 64, 64), mk_rect(0, 300, 0, -32768, 64, 64));
    send_directed(mk_rect(0, 0, 11585, 11585, 64, 64), mk_rect(60, 60, 16384, 0, 32, 32));
    send_directed(mk_rect(0, 0, 11585, -11585, 64, 64), mk_rect(45, 45, 16384, 0, 32, 32));
    // unscaled directions
    send_directed(mk_rect(0, 0, 1, 0, 64, 16), mk_rect(50, 0, 32767, 5, 64, 16));
    send_directed(mk_rect(0, 0, 16384, 16384, 40, 20), mk_rect(30, -30, -16384, 16384, 40, 20));
    send_directed(mk_rect(5, 5, 16384, 0, 0, 0), mk_rect(5, 5, 0, 16384, 0, 0));
    send_directed(mk_rect(5, 5, 16384, 0, 0, 0), mk_rect(6, 5, 0, 16384, 0, 0));
    send_directed(mk_rect(-1, -1, 32767, -1, 32767, 0), mk_rect(0, 0, -1, 32767, 0, 32767));
    send_directed(mk_rect(-21846, 21845, -21846, 21845, 21845, 10922),
                  mk_rect(21845, -21846, 21845, -21846, 10922, 21845));

    for (int i = 0; i < NumRandom; i++) begin
      steady = (i >= 150 && i < 250);
      send_random();
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.pending() > 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    $display("%0d rectangle pairs sent (%0d directed), %0d results checked",
             sent, directed_count, sb.checked);
    $display("%0d overlapping, %0d separated, %0d mismatches",
             sb.overlaps, sb.checked - sb.overlaps, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("oriented_rect_overlap_test_core_test: done, clean");
    end else begin
      $display("oriented_rect_overlap_test_core_test: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/oro_pkg.sv
src/oro_axis.sv
src/oriented_rect_overlap_test_core.sv
tb/oriented_rect_overlap_test_core_test.sv
